// ===== rtl/pssp_pkg.sv =====
package pssp_pkg;

   localparam int PIX_W   = 12;
   localparam int COLOR_W = 24;
   localparam int ADDR_W  = 5;

   localparam int NSTAGE = 73;
   localparam int LAST   = NSTAGE - 1;

   localparam logic [12:0] MAX_DIM   = 13'd4096;
   localparam logic [16:0] FONE      = 17'd65536;
   localparam logic [16:0] FLOOR_B   = 17'd6554;
   localparam logic [16:0] COEF_0P2  = 17'd13107;
   localparam logic [16:0] COEF_0P05 = 17'd3277;
   localparam logic [16:0] COEF_0P1  = 17'd6554;
   localparam logic [COLOR_W-1:0] COLOR_MAX = 24'hFFFFFF;

   // index 0 red, 1 green, 2 blue
   localparam logic [2:0][16:0] ZEN_C  = {17'd58982, 17'd32768, 17'd19661};
   localparam logic [2:0][16:0] HOR_C  = {17'd65536, 17'd52429, 17'd45875};
   localparam logic [2:0][16:0] SUN_C  = {17'd58982, 17'd65536, 17'd65536};
   localparam logic [2:0][16:0] GLOW_C = {17'd45875, 17'd58982, 17'd65536};

   localparam logic [2:0] REG_WIDTH     = 3'd0;
   localparam logic [2:0] REG_HEIGHT    = 3'd1;
   localparam logic [2:0] REG_ALTITUDE  = 3'd2;
   localparam logic [2:0] REG_AZIMUTH   = 3'd3;
   localparam logic [2:0] REG_SIZE      = 3'd4;
   localparam logic [2:0] REG_INTENSITY = 3'd5;

   localparam logic [12:0] RST_WIDTH     = 13'd2048;
   localparam logic [12:0] RST_HEIGHT    = 13'd1024;
   localparam logic [16:0] RST_ALTITUDE  = 17'd26214;
   localparam logic [16:0] RST_AZIMUTH   = 17'd32768;
   localparam logic [16:0] RST_SIZE      = 17'd655;
   localparam logic [15:0] RST_INTENSITY = 16'd12800;

   typedef struct packed {
      logic [59:0] rad;
      logic [31:0] rem;
      logic [29:0] root;
   } sqb_type;

   typedef struct packed {
      logic [33:0] rad;
      logic [18:0] rem;
      logic [16:0] root;
   } sqs_type;

   typedef struct packed {
      logic [12:0]        w;
      logic [12:0]        h;
      logic [11:0]        hm1;
      logic               h_ok;
      logic [28:0]        sx;
      logic signed [29:0] sy;
      logic [28:0]        r;
      logic [32:0]        r10;
      logic [15:0]        inten;
   } der_type;

   typedef struct packed {
      logic [PIX_W-1:0]  x;
      logic [PIX_W-1:0]  y;
      logic [28:0]       dxa;
      logic [28:0]       dya;
      logic [57:0]       dx2;
      logic [57:0]       dy2;
      sqb_type           dq;
      logic [27:0]       a_rem;
      logic [11:0]       a_den;
      logic [16:0]       a_q;
      logic [16:0]       u;
      logic [16:0]       uu;
      sqs_type           us;
      logic [2:0][16:0]  col;
      logic [16:0]       scat;
      logic [16:0]       sc_a;
      logic [16:0]       sc_b;
      logic              disk;
      logic              glow;
      logic [48:0]       b_rem;
      logic [32:0]       b_den;
      logic [16:0]       b_q;
      sqs_type           fs;
      logic [16:0]       g2;
      logic [23:0]       gt;
      logic [20:0]       gi;
      logic [2:0][16:0]  keep;
      logic [2:0][16:0]  sa;
      logic [2:0][20:0]  ga;
      logic [2:0][24:0]  res;
      logic [2:0][COLOR_W-1:0] out;
   } pix_type;

endpackage

// ===== rtl/pssp_req_if.sv =====
interface pssp_req_if;
   logic                      valid;
   logic                      ready;
   logic [pssp_pkg::PIX_W-1:0] pixel_x;
   logic [pssp_pkg::PIX_W-1:0] pixel_y;

   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

// ===== rtl/pssp_rsp_if.sv =====
interface pssp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [pssp_pkg::COLOR_W-1:0] red;
   logic [pssp_pkg::COLOR_W-1:0] green;
   logic [pssp_pkg::COLOR_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ===== rtl/procedural_sky_sun_pixel_core.sv =====
// channel   direction  payload                   handshake
// req_ch    in         pixel_x, pixel_y          valid/ready
// rsp_ch    out        red, green, blue Q8.16    valid/ready
// csr       in         APB write/read, regs 0-5  psel/penable, pready tied high
//
// One item per cycle unless the pipeline holds; each item passes through the stage registers, then the output register.
// Depth is set by the 30-step distance square root, the two 17-step dividers
// and the 17-step square roots, one step per stage.
// Synchronous reset clears the valid bits and loads the register defaults.
// The pipeline holds only when its last stage is full and the output item waits.
module procedural_sky_sun_pixel_core (
   input  logic                        clock,
   input  logic                        reset,
   pssp_req_if.sink                    req_ch,
   pssp_rsp_if.source                  rsp_ch,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [pssp_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);

   logic [12:0] cfg_width_ff;
   logic [12:0] cfg_height_ff;
   logic [16:0] cfg_alt_ff;
   logic [16:0] cfg_az_ff;
   logic [16:0] cfg_size_ff;
   logic [15:0] cfg_int_ff;

   pssp_pkg::der_type der_ff, der_in;
   pssp_pkg::pix_type st_ff [pssp_pkg::NSTAGE];
   pssp_pkg::pix_type st_in [1:pssp_pkg::NSTAGE-1];
   logic [pssp_pkg::NSTAGE-1:0] v_ff;

   logic                          rsp_valid_ff;
   logic [pssp_pkg::COLOR_W-1:0]  rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic                          out_free, en;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= pssp_pkg::RST_WIDTH;
         cfg_height_ff <= pssp_pkg::RST_HEIGHT;
         cfg_alt_ff    <= pssp_pkg::RST_ALTITUDE;
         cfg_az_ff     <= pssp_pkg::RST_AZIMUTH;
         cfg_size_ff   <= pssp_pkg::RST_SIZE;
         cfg_int_ff    <= pssp_pkg::RST_INTENSITY;
      end else if (psel && penable && pwrite) begin
         case (paddr[4:2])
            pssp_pkg::REG_WIDTH:     cfg_width_ff  <= pwdata[12:0];
            pssp_pkg::REG_HEIGHT:    cfg_height_ff <= pwdata[12:0];
            pssp_pkg::REG_ALTITUDE:  cfg_alt_ff    <= pwdata[16:0];
            pssp_pkg::REG_AZIMUTH:   cfg_az_ff     <= pwdata[16:0];
            pssp_pkg::REG_SIZE:      cfg_size_ff   <= pwdata[16:0];
            pssp_pkg::REG_INTENSITY: cfg_int_ff    <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         pssp_pkg::REG_WIDTH:     prdata = 32'(cfg_width_ff);
         pssp_pkg::REG_HEIGHT:    prdata = 32'(cfg_height_ff);
         pssp_pkg::REG_ALTITUDE:  prdata = 32'(cfg_alt_ff);
         pssp_pkg::REG_AZIMUTH:   prdata = 32'(cfg_az_ff);
         pssp_pkg::REG_SIZE:      prdata = 32'(cfg_size_ff);
         pssp_pkg::REG_INTENSITY: prdata = 32'(cfg_int_ff);
         default:                 prdata = 32'd0;
      endcase
   end

   // values that depend on the registers only
   always_comb begin
      logic [12:0]        mn;
      logic signed [17:0] dif;
      logic signed [31:0] syp;
      der_in.w = (cfg_width_ff > pssp_pkg::MAX_DIM) ? pssp_pkg::MAX_DIM : cfg_width_ff;
      der_in.h = (cfg_height_ff > pssp_pkg::MAX_DIM) ? pssp_pkg::MAX_DIM : cfg_height_ff;
      der_in.h_ok = (der_in.h >= 13'd2);
      der_in.hm1 = 12'(der_in.h - 13'd1);
      mn = (der_in.w < der_in.h) ? der_in.w : der_in.h;
      der_in.sx = 29'(30'(der_in.w) * 30'(cfg_az_ff));
      dif = 18'sd65536 - $signed({1'b0, cfg_alt_ff});
      syp = $signed({19'd0, der_in.h}) * 32'(dif);
      der_in.sy = syp[29:0];
      der_in.r = 29'(30'(mn) * 30'(cfg_size_ff));
      der_in.r10 = 33'(der_ff.r) * 33'd10;
      der_in.inten = cfg_int_ff;
   end

   always_ff @(posedge clock) begin
      der_ff <= der_in;
   end

   function automatic logic [16:0] fmul17(input logic [16:0] a, input logic [16:0] b);
      logic [33:0] p;
      p = 34'(a) * 34'(b) + 34'd32768;
      return p[32:16];
   endfunction

   function automatic pssp_pkg::sqb_type sqb_step(input pssp_pkg::sqb_type s);
      pssp_pkg::sqb_type n;
      logic [33:0] r2;
      logic [33:0] tr;
      r2 = {s.rem, s.rad[59:58]};
      tr = {2'b00, s.root, 2'b01};
      n.rad = s.rad << 2;
      if (r2 >= tr) begin
         n.rem  = 32'(r2 - tr);
         n.root = {s.root[28:0], 1'b1};
      end else begin
         n.rem  = 32'(r2);
         n.root = {s.root[28:0], 1'b0};
      end
      return n;
   endfunction

   function automatic pssp_pkg::sqs_type sqs_step(input pssp_pkg::sqs_type s);
      pssp_pkg::sqs_type n;
      logic [20:0] r2;
      logic [20:0] tr;
      r2 = {s.rem, s.rad[33:32]};
      tr = {2'b00, s.root, 2'b01};
      n.rad = s.rad << 2;
      if (r2 >= tr) begin
         n.rem  = 19'(r2 - tr);
         n.root = {s.root[15:0], 1'b1};
      end else begin
         n.rem  = 19'(r2);
         n.root = {s.root[15:0], 1'b0};
      end
      return n;
   endfunction

   function automatic pssp_pkg::pix_type step_fn(input int i, input pssp_pkg::pix_type p,
                                                 input pssp_pkg::der_type d);
      pssp_pkg::pix_type n;
      int                k;
      logic [27:0]       ta;
      logic [48:0]       tb;
      logic signed [30:0] dxs, dys;
      logic [34:0]       acc;
      logic [17:0]       t18;
      logic              dk, gl;
      logic [32:0]       dsel;
      logic [32:0]       p33;
      logic [37:0]       p38;
      n = p;
      if (i == 1) begin
         dxs = $signed({3'b000, p.x, 16'h0000}) - $signed({2'b00, d.sx});
         dys = $signed({3'b000, p.y, 16'h0000}) - $signed({d.sy[29], d.sy});
         n.dxa = dxs[30] ? 29'(-dxs) : dxs[28:0];
         n.dya = dys[30] ? 29'(-dys) : dys[28:0];
         if (d.h_ok && (({1'b0, p.y} + 13'd1) < d.h)) begin
            n.a_rem = {d.hm1 - p.y, 16'h0000};
            n.a_den = d.hm1;
         end else begin
            n.a_rem = 28'd0;
            n.a_den = 12'd1;
         end
         n.a_q = 17'd0;
      end
      if (i == 2) begin
         n.dx2 = 58'(p.dxa) * 58'(p.dxa);
         n.dy2 = 58'(p.dya) * 58'(p.dya);
      end
      if (i == 3) begin
         n.dq.rad  = {1'b0, 59'(p.dx2) + 59'(p.dy2)};
         n.dq.rem  = 32'd0;
         n.dq.root = 30'd0;
      end
      if (i >= 2 && i <= 18) begin
         k  = 18 - i;
         ta = 28'(p.a_den) << k;
         if (p.a_rem >= ta) begin
            n.a_rem  = p.a_rem - ta;
            n.a_q[k] = 1'b1;
         end
      end
      if (i >= 4 && i <= 33) begin
         n.dq = sqb_step(p.dq);
      end
      if (i == 19) begin
         n.u = pssp_pkg::FONE - p.a_q;
      end
      if (i == 20) begin
         n.uu = fmul17(p.u, p.u);
         for (int c = 0; c < 3; c++) begin
            acc = 35'(pssp_pkg::HOR_C[c]) * 35'(p.u) + 35'(pssp_pkg::ZEN_C[c]) * 35'(p.a_q)
                  + 35'd32768;
            n.col[c] = acc[32:16];
         end
         n.us.rad  = {1'b0, p.u, 16'h0000};
         n.us.rem  = 19'd0;
         n.us.root = 17'd0;
      end
      if (i >= 21 && i <= 37) begin
         n.us = sqs_step(p.us);
      end
      if (i == 38) begin
         n.scat = fmul17(p.uu, p.us.root);
      end
      if (i == 39) begin
         n.sc_a = fmul17(p.scat, pssp_pkg::COEF_0P2);
         n.sc_b = fmul17(p.scat, pssp_pkg::COEF_0P05);
      end
      if (i == 40) begin
         t18 = 18'(p.col[0]) + 18'(p.sc_a);
         n.col[0] = (t18 > 18'(pssp_pkg::FONE)) ? pssp_pkg::FONE : t18[16:0];
         t18 = 18'(p.col[1]) + 18'(p.sc_b);
         n.col[1] = (t18 > 18'(pssp_pkg::FONE)) ? pssp_pkg::FONE : t18[16:0];
         if (18'(p.col[2]) >= 18'(p.sc_a) + 18'(pssp_pkg::FLOOR_B)) begin
            n.col[2] = p.col[2] - p.sc_a;
         end else begin
            n.col[2] = pssp_pkg::FLOOR_B;
         end
      end
      if (i == 34) begin
         dk = (p.dq.root < 30'(d.r));
         gl = !dk && (33'(p.dq.root) < d.r10);
         dsel = dk ? 33'(d.r) : d.r10;
         n.disk = dk;
         n.glow = gl;
         if (dk || gl) begin
            n.b_rem = {dsel - 33'(p.dq.root), 16'h0000};
            n.b_den = dsel;
         end else begin
            n.b_rem = 49'd0;
            n.b_den = 33'd1;
         end
         n.b_q = 17'd0;
      end
      if (i >= 35 && i <= 51) begin
         k  = 51 - i;
         tb = 49'(p.b_den) << k;
         if (p.b_rem >= tb) begin
            n.b_rem  = p.b_rem - tb;
            n.b_q[k] = 1'b1;
         end
      end
      if (i == 52) begin
         n.fs.rad  = {1'b0, p.b_q, 16'h0000};
         n.fs.rem  = 19'd0;
         n.fs.root = 17'd0;
         n.g2 = fmul17(p.b_q, p.b_q);
      end
      if (i >= 53 && i <= 69) begin
         n.fs = sqs_step(p.fs);
      end
      if (i == 53) begin
         p33  = 33'(d.inten) * 33'(p.g2) + 33'd128;
         n.gt = p33[31:8];
      end
      if (i == 54) begin
         p38  = 38'(p.gt) * 38'(pssp_pkg::COEF_0P1) + 38'd32768;
         n.gi = p38[36:16];
      end
      if (i == 70) begin
         for (int c = 0; c < 3; c++) begin
            n.keep[c] = fmul17(p.col[c], pssp_pkg::FONE - p.fs.root);
            n.sa[c]   = fmul17(pssp_pkg::SUN_C[c], p.fs.root);
            p38 = 38'(pssp_pkg::GLOW_C[c]) * 38'(p.gi) + 38'd32768;
            n.ga[c] = p38[36:16];
         end
      end
      if (i == 71) begin
         for (int c = 0; c < 3; c++) begin
            if (p.disk) begin
               p33 = 33'(p.sa[c]) * 33'(d.inten) + 33'd128;
               n.res[c] = 25'(p.keep[c]) + 25'(p33[32:8]);
            end else if (p.glow) begin
               n.res[c] = 25'(p.col[c]) + 25'(p.ga[c]);
            end else begin
               n.res[c] = 25'(p.col[c]);
            end
         end
      end
      if (i == 72) begin
         for (int c = 0; c < 3; c++) begin
            n.out[c] = (p.res[c] > 25'(pssp_pkg::COLOR_MAX)) ? pssp_pkg::COLOR_MAX
                                                              : p.res[c][23:0];
         end
      end
      return n;
   endfunction

   for (genvar s = 1; s < pssp_pkg::NSTAGE; s++) begin : g_stage
      always_comb begin
         st_in[s] = step_fn(s, st_ff[s-1], der_ff);
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign en = !v_ff[pssp_pkg::LAST] || out_free;
   assign req_ch.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[pssp_pkg::NSTAGE-2:0], req_ch.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0] <= {req_ch.pixel_x, req_ch.pixel_y,
                      {($bits(pssp_pkg::pix_type) - 2 * pssp_pkg::PIX_W){1'b0}}};
         for (int s = 1; s < pssp_pkg::NSTAGE; s++) begin
            st_ff[s] <= st_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= v_ff[pssp_pkg::LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && v_ff[pssp_pkg::LAST]) begin
         rsp_red_ff   <= st_ff[pssp_pkg::LAST].out[0];
         rsp_green_ff <= st_ff[pssp_pkg::LAST].out[1];
         rsp_blue_ff  <= st_ff[pssp_pkg::LAST].out[2];
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.red   = rsp_red_ff;
   assign rsp_ch.green = rsp_green_ff;
   assign rsp_ch.blue  = rsp_blue_ff;

endmodule
